@@ hw/rtl/ccf_pkg.sv @@
// Shared constants for the two-point circle center pipeline.
// Depends on nothing; used by the interfaces and the top level.
package ccf_pkg;

  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TWO  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INF  = 2'd3;

  // Fraction bits of the ratio before the root, and of the root itself.
  localparam int RATIO_SHIFT = 32;
  localparam int ROOT_SHIFT  = 16;

endpackage

@@ hw/rtl/ccf_if.sv @@
// Valid/ready channel interfaces for the circle center pipeline.
// Depends on ccf_pkg for the solution kind width.
interface ccf_in_if #(
  parameter int CW = 24
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] first_x;
  logic [CW-1:0] first_y;
  logic [CW-1:0] second_x;
  logic [CW-1:0] second_y;
  logic [CW-2:0] circle_radius;

  modport source (output valid, first_x, first_y, second_x, second_y, circle_radius,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, circle_radius,
                output ready);
endinterface

interface ccf_out_if #(
  parameter int CW = 24
);
  logic                      valid;
  logic                      ready;
  logic [ccf_pkg::KIND_W-1:0] solution_kind;
  logic [CW-1:0]             center_one_x;
  logic [CW-1:0]             center_one_y;
  logic [CW-1:0]             center_two_x;
  logic [CW-1:0]             center_two_y;

  modport source (output valid, solution_kind, center_one_x, center_one_y, center_two_x,
                  center_two_y, input ready);
  modport sink (input valid, solution_kind, center_one_x, center_one_y, center_two_x,
                center_two_y, output ready);
endinterface

@@ hw/rtl/circle_centers_from_two_points_top.sv @@
// Top level of the circle center pipeline: two points and a radius in, solution kind
// and two saturated centers out. Depends on ccf_pkg and the interfaces in ccf_if.sv.
//
// Usage: each request on in_chan carries two signed fixed-point points and an unsigned
// radius; each one produces exactly one result on out_chan, in order. Both channels
// use valid/ready and a request moves when both are high.
// The pipeline has three front stages for differences, squares and classification,
// one stage per quotient bit of the restoring divider (2*COORD_BITS+32 stages), one
// stage per root bit of the square root (COORD_BITS+16 stages), and three stages for
// the offset multiply and the saturating center sums. A new request is taken every
// cycle while the output is not stalled.
// The whole pipeline advances together; when out_chan.ready is low while a result is
// waiting, every stage holds and in_chan.ready drops in the same cycle, so nothing is
// lost or repeated. Bubbles inside the pipeline are not squeezed out.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
module circle_centers_from_two_points_top #(
  parameter int COORD_BITS = 24
) (
  input logic      clk,
  input logic      rst_n,
  ccf_in_if.sink   in_chan,
  ccf_out_if.source out_chan
);

  localparam int C    = COORD_BITS;
  localparam int D2W  = 2 * C + 2;
  localparam int DW   = D2W + 2;
  localparam int NUMW = 2 * C;
  localparam int NW   = NUMW + ccf_pkg::RATIO_SHIFT;
  localparam int RW   = NW / 2;
  localparam int SW   = RW + 2;
  localparam int LW   = RW / 2;
  localparam int HW   = RW - LW;
  localparam int MW   = RW + C + 1;
  localparam int OW   = MW - ccf_pkg::ROOT_SHIFT + 1;
  localparam int TW   = OW + 1;

  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
  localparam logic [MW-1:0] ROUND_UP = MW'((64'd1 << ccf_pkg::ROOT_SHIFT) - 64'd1);

  typedef struct packed {
    logic [ccf_pkg::KIND_W-1:0] kind;
    logic signed [C-1:0]        mx;
    logic signed [C-1:0]        my;
    logic [C:0]                 ax;
    logic [C:0]                 ay;
    logic                       nx;
    logic                       ny;
  } geo_t;

  logic en;
  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  // Stage 1: differences, magnitudes and floor midpoint.
  logic          v1_r;
  geo_t          g1_r;
  logic [C-2:0]  rad1_r;
  logic signed [C:0] x1_w, y1_w, x2_w, y2_w, sy_w, dx_w;

  always_comb begin
    x1_w = (C+1)'(signed'(in_chan.first_x));
    y1_w = (C+1)'(signed'(in_chan.first_y));
    x2_w = (C+1)'(signed'(in_chan.second_x));
    y2_w = (C+1)'(signed'(in_chan.second_y));
    sy_w = y1_w - y2_w;
    dx_w = x2_w - x1_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r.kind <= ccf_pkg::KIND_NONE;
      g1_r.mx   <= C'((x1_w + x2_w) >>> 1);
      g1_r.my   <= C'((y1_w + y2_w) >>> 1);
      g1_r.nx   <= sy_w[C];
      g1_r.ny   <= dx_w[C];
      g1_r.ax   <= sy_w[C] ? (C+1)'(-sy_w) : (C+1)'(sy_w);
      g1_r.ay   <= dx_w[C] ? (C+1)'(-dx_w) : (C+1)'(dx_w);
      rad1_r    <= in_chan.circle_radius;
    end
  end

  // Stage 2: squares.
  logic              v2_r;
  geo_t              g2_r;
  logic [2*C+1:0]    sqx_r, sqy_r;
  logic [2*C-3:0]    rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_r  <= g1_r;
      sqx_r <= g1_r.ay * g1_r.ay;
      sqy_r <= g1_r.ax * g1_r.ax;
      rr_r  <= rad1_r * rad1_r;
    end
  end

  // Stage 3 and divider: element 0 is the classification stage.
  logic             dvld [0:NW];
  geo_t             dgeo [0:NW];
  logic [NUMW-1:0]  dnum [0:NW];
  logic [DW-1:0]    dden [0:NW];
  logic [DW-1:0]    drem [0:NW];
  logic [NW-1:0]    dq   [0:NW];

  logic [D2W-1:0] d2_w;
  logic [D2W-1:0] f4_w;
  logic [ccf_pkg::KIND_W-1:0] kind_w;
  geo_t           geo3_w;

  always_comb begin
    d2_w = sqx_r + sqy_r;
    f4_w = D2W'({rr_r, 2'b00});
    if (d2_w == '0) begin
      kind_w = (rr_r == '0) ? ccf_pkg::KIND_NONE : ccf_pkg::KIND_INF;
    end else if (d2_w == f4_w) begin
      kind_w = ccf_pkg::KIND_ONE;
    end else if (d2_w > f4_w) begin
      kind_w = ccf_pkg::KIND_NONE;
    end else begin
      kind_w = ccf_pkg::KIND_TWO;
    end
    geo3_w      = g2_r;
    geo3_w.kind = kind_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dgeo[0]      <= geo3_w;
      dnum[0]      <= (kind_w == ccf_pkg::KIND_TWO) ? NUMW'(f4_w - d2_w) : '0;
      dden[0]      <= {d2_w, 2'b00};
      drem[0]      <= '0;
      dq[0]        <= '0;
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    localparam int BI = NW - 1 - s;
    logic         dbit;
    logic [DW:0]  cur;
    logic         ge;

    if (BI >= ccf_pkg::RATIO_SHIFT) begin : g_bit
      assign dbit = dnum[s][BI - ccf_pkg::RATIO_SHIFT];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign cur = {drem[s], dbit};
    assign ge  = cur >= {1'b0, dden[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld[s+1] <= 1'b0;
      end else if (en) begin
        dvld[s+1] <= dvld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dgeo[s+1] <= dgeo[s];
        dnum[s+1] <= dnum[s];
        dden[s+1] <= dden[s];
        drem[s+1] <= ge ? DW'(cur - {1'b0, dden[s]}) : DW'(cur);
        dq[s+1]   <= {dq[s][NW-2:0], ge};
      end
    end
  end

  // Square root, two radicand bits per stage.
  logic          svld  [0:RW-1];
  geo_t          sgeo  [0:RW-1];
  logic [NW-1:0] squo  [0:RW-1];
  logic [RW-1:0] sroot [0:RW-1];
  logic [SW-1:0] srem  [0:RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_sqr
    localparam int PI = RW - 1 - j;
    logic          pv;
    geo_t          pg;
    logic [NW-1:0] pq;
    logic [RW-1:0] pr;
    logic [SW-1:0] ps;
    logic [SW-1:0] cur;
    logic [SW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign pv = dvld[NW];
      assign pg = dgeo[NW];
      assign pq = dq[NW];
      assign pr = '0;
      assign ps = '0;
    end else begin : g_next
      assign pv = svld[j-1];
      assign pg = sgeo[j-1];
      assign pq = squo[j-1];
      assign pr = sroot[j-1];
      assign ps = srem[j-1];
    end

    assign cur   = {ps[SW-3:0], pq[2*PI+1 -: 2]};
    assign trial = {pr, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld[j] <= 1'b0;
      end else if (en) begin
        svld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sgeo[j]  <= pg;
        squo[j]  <= pq;
        sroot[j] <= {pr[RW-2:0], ge};
        srem[j]  <= ge ? (cur - trial) : cur;
      end
    end
  end

  // Offset multiply in two halves of the root.
  logic             p1v_r;
  geo_t             p1g_r;
  logic [LW+C:0]    plx_r, ply_r;
  logic [HW+C:0]    phx_r, phy_r;
  logic [RW-1:0]    froot;

  assign froot = sroot[RW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
    end else if (en) begin
      p1v_r <= svld[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1g_r <= sgeo[RW-1];
      plx_r <= froot[LW-1:0] * sgeo[RW-1].ax;
      ply_r <= froot[LW-1:0] * sgeo[RW-1].ay;
      phx_r <= froot[RW-1:LW] * sgeo[RW-1].ax;
      phy_r <= froot[RW-1:LW] * sgeo[RW-1].ay;
    end
  end

  // Combine halves, floor divide by the root scale.
  logic                p2v_r;
  geo_t                p2g_r;
  logic signed [OW-1:0] ox_r, oy_r;
  logic [MW-1:0]       mxp_w, myp_w;

  always_comb begin
    mxp_w = (MW'(phx_r) << LW) + MW'(plx_r);
    myp_w = (MW'(phy_r) << LW) + MW'(ply_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2v_r <= 1'b0;
    end else if (en) begin
      p2v_r <= p1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2g_r <= p1g_r;
      ox_r  <= p1g_r.nx ? -OW'((mxp_w + ROUND_UP) >> ccf_pkg::ROOT_SHIFT)
                        : OW'(mxp_w >> ccf_pkg::ROOT_SHIFT);
      oy_r  <= p1g_r.ny ? -OW'((myp_w + ROUND_UP) >> ccf_pkg::ROOT_SHIFT)
                        : OW'(myp_w >> ccf_pkg::ROOT_SHIFT);
    end
  end

  // Center sums, saturation and the output register.
  logic                        vout_r;
  logic [ccf_pkg::KIND_W-1:0]  kind_r;
  logic [C-1:0]                c1x_r, c1y_r, c2x_r, c2y_r;
  logic signed [TW-1:0]        ex_w, ey_w, s1x_w, s1y_w, s2x_w, s2y_w;

  function automatic logic [C-1:0] sat(input logic signed [TW-1:0] v);
    logic [C-1:0] res;
    if (v > SAT_HI) begin
      res = C'(SAT_HI);
    end else if (v < SAT_LO) begin
      res = C'(SAT_LO);
    end else begin
      res = C'(v);
    end
    return res;
  endfunction

  always_comb begin
    ex_w  = (p2g_r.kind == ccf_pkg::KIND_TWO) ? TW'(ox_r) : '0;
    ey_w  = (p2g_r.kind == ccf_pkg::KIND_TWO) ? TW'(oy_r) : '0;
    s1x_w = TW'(p2g_r.mx) + ex_w;
    s1y_w = TW'(p2g_r.my) + ey_w;
    s2x_w = TW'(p2g_r.mx) - ex_w;
    s2y_w = TW'(p2g_r.my) - ey_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= p2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= p2g_r.kind;
      if (p2g_r.kind == ccf_pkg::KIND_ONE || p2g_r.kind == ccf_pkg::KIND_TWO) begin
        c1x_r <= sat(s1x_w);
        c1y_r <= sat(s1y_w);
        c2x_r <= sat(s2x_w);
        c2y_r <= sat(s2y_w);
      end else begin
        c1x_r <= '0;
        c1y_r <= '0;
        c2x_r <= '0;
        c2y_r <= '0;
      end
    end
  end

  assign out_chan.valid         = vout_r;
  assign out_chan.solution_kind = kind_r;
  assign out_chan.center_one_x  = c1x_r;
  assign out_chan.center_one_y  = c1y_r;
  assign out_chan.center_two_x  = c2x_r;
  assign out_chan.center_two_y  = c2y_r;

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vout_r && (kind_r == ccf_pkg::KIND_NONE || kind_r == ccf_pkg::KIND_INF) |->
    c1x_r == '0 && c1y_r == '0 && c2x_r == '0 && c2y_r == '0)
    else $error("centers not cleared for an empty solution");

  a_one_same: assert property (@(posedge clk) disable iff (!rst_n)
    vout_r && kind_r == ccf_pkg::KIND_ONE |-> c1x_r == c2x_r && c1y_r == c2y_r)
    else $error("single solution has two different centers");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dvld[0]) && $stable(svld[RW-1]) && $stable(kind_r))
    else $error("pipeline moved during a stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready == (!vout_r || out_chan.ready))
    else $error("input ready does not follow the output stage");

endmodule
